>>> rtl/allocation_leak_tracker_core_defines.svh
// assertion macros shared by the allocation leak tracker rtl
`ifndef ALLOCATION_LEAK_TRACKER_CORE_DEFINES_SVH
`define ALLOCATION_LEAK_TRACKER_CORE_DEFINES_SVH

// checked on every clock edge outside reset
`define ALT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every clock edge, reset included
`define ALT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/alt_pkg.sv
// types and constants shared by the allocation leak tracker modules
`default_nettype none

package alt_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // word index of the tracking enable register
    localparam logic REG_TRACK_ENABLE = 1'b0;

    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] STS_DONE      = 2'd0;
    localparam logic [1:0] STS_IGNORED   = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] address;
        logic [31:0] length;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] live_count;
        logic [31:0]        live_total;
    } rsp_t;

    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] length;
        logic [31:0] address;
    } entry_t;

    typedef enum logic [1:0] {
        K_ADD,
        K_DEL,
        K_CLEAR,
        K_IGNORE
    } kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic rd_issue;
        logic sweep_wr;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        kind_t in_kind;
        kind_t kind;
        logic  issue_done;
        logic  rd_pending;
        logic  found;
        logic  out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/alt_ctrl.sv
// controller state machine for the allocation leak tracker
`default_nettype none
`include "allocation_leak_tracker_core_defines.svh"

module alt_ctrl
    import alt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire dp_sts_t  sts,
    output ctl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   scan_end;

    // add stops at the first free slot, delete walks the whole table
    assign scan_end = ((sts.kind == K_ADD) && sts.found) ||
                      (sts.issue_done && !sts.rd_pending);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (sts.issue_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (sts.in_kind)
                        K_CLEAR:      state_next = ST_SWEEP;
                        K_IGNORE:     state_next = ST_COMMIT;
                        K_ADD, K_DEL: state_next = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_SWEEP:
            begin
                if (sts.issue_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        req_ready    = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_wr = !sts.issue_done;
            end
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_SCAN:
            begin
                cmd.rd_issue = !sts.issue_done && !((sts.kind == K_ADD) && sts.found);
            end
            ST_SWEEP:
            begin
                cmd.sweep_wr = !sts.issue_done;
            end
            ST_COMMIT:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    `ALT_ASSERT(a_commit_needs_room, cmd.commit |-> sts.out_free, "commit with output busy")
    `ALT_ASSERT(a_scan_exits, (state_reg == ST_SCAN) && sts.issue_done && !sts.rd_pending |=> (state_reg == ST_COMMIT), "scan did not end after last entry")
    `ALT_ASSERT(a_one_port_use, !(cmd.rd_issue && cmd.sweep_wr), "read and sweep in one cycle")

endmodule

`default_nettype wire

>>> rtl/alt_dp.sv
// datapath: entry table memory, scan compare, counters and result register
`default_nettype none
`include "allocation_leak_tracker_core_defines.svh"

module alt_dp
    import alt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ctl_cmd_t cmd,
    input  wire logic     track_en,
    input  wire req_t     req_data,
    input  wire logic     rsp_ready,
    output dp_sts_t       sts,
    output logic          rsp_valid,
    output rsp_t          rsp_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    entry_t mem [TABLE_ENTRIES];
    entry_t mem_q;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    kind_t             in_kind;
    kind_t             kind_reg;
    logic [31:0]       addr_reg;
    logic [31:0]       len_reg;

    logic [CNT_W-1:0]  issue_idx_reg;
    logic [CNT_W-1:0]  issue_idx_next;
    logic              rd_pending_reg;
    logic [IDX_W-1:0]  rd_idx_reg;

    logic              found_reg;
    logic              found_next;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [IDX_W-1:0]  best_idx_next;
    logic [31:0]       best_age_reg;
    logic [31:0]       best_age_next;
    logic [31:0]       best_len_reg;
    logic [31:0]       best_len_next;
    logic [31:0]       age;

    logic [31:0]       add_seq_reg;
    logic [31:0]       add_seq_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [31:0]       sum_reg;
    logic [31:0]       sum_next;

    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              out_free;

    logic [IDX_W+SLOT_W-1:0]  slot_ext;
    logic [CNT_W+COUNT_W-1:0] count_ext;
    logic [1:0]               res_status;
    logic                     res_slot_sel;

    // item decode on the request word
    always_comb
    begin
        in_kind = K_IGNORE;
        if (req_data.opcode == OP_CLEAR)
        begin
            in_kind = K_CLEAR;
        end
        else if (track_en && (req_data.address != '0))
        begin
            if (req_data.opcode == OP_ADD)
            begin
                in_kind = K_ADD;
            end
            else if (req_data.opcode == OP_DELETE)
            begin
                in_kind = K_DEL;
            end
        end
    end

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign age      = add_seq_reg - mem_q.stamp;

    // scan counter, shared by table reads and clearing writes
    always_comb
    begin
        issue_idx_next = issue_idx_reg;
        if (cmd.capture)
        begin
            issue_idx_next = '0;
        end
        else if (cmd.rd_issue || cmd.sweep_wr)
        begin
            issue_idx_next = issue_idx_reg + CNT_W'(1);
        end
    end

    // compare of the entry read in the previous cycle
    always_comb
    begin
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_age_next = best_age_reg;
        best_len_next = best_len_reg;
        if (cmd.capture)
        begin
            found_next = 1'b0;
        end
        else if (rd_pending_reg)
        begin
            case (kind_reg)
                K_ADD:
                begin
                    if (!found_reg && (mem_q.address == '0))
                    begin
                        found_next    = 1'b1;
                        best_idx_next = rd_idx_reg;
                    end
                end
                K_DEL:
                begin
                    // strict compare keeps the lowest slot on equal age
                    if ((mem_q.address == addr_reg) && (!found_reg || (age < best_age_reg)))
                    begin
                        found_next    = 1'b1;
                        best_idx_next = rd_idx_reg;
                        best_age_next = age;
                        best_len_next = mem_q.length;
                    end
                end
                default:
                begin
                    found_next = found_reg;
                end
            endcase
        end
    end

    // commit of the item: table update, totals and result word
    always_comb
    begin
        add_seq_next   = add_seq_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        res_status     = STS_IGNORED;
        res_slot_sel   = 1'b0;
        wr_en          = cmd.sweep_wr;
        wr_addr        = issue_idx_reg[IDX_W-1:0];
        wr_data        = '0;
        if (cmd.commit)
        begin
            unique case (kind_reg)
                K_ADD:
                begin
                    if (found_reg)
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = best_idx_reg;
                        wr_data.stamp   = add_seq_reg;
                        wr_data.length  = len_reg;
                        wr_data.address = addr_reg;
                        add_seq_next    = add_seq_reg + 32'd1;
                        count_next      = count_reg + CNT_W'(1);
                        sum_next        = sum_reg + len_reg;
                        res_status      = STS_DONE;
                        res_slot_sel    = 1'b1;
                    end
                    else
                    begin
                        res_status = STS_FULL;
                    end
                end
                K_DEL:
                begin
                    if (found_reg)
                    begin
                        wr_en        = 1'b1;
                        wr_addr      = best_idx_reg;
                        sum_next     = sum_reg - best_len_reg;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        res_status   = STS_DONE;
                        res_slot_sel = 1'b1;
                    end
                    else
                    begin
                        res_status = STS_NOT_FOUND;
                    end
                end
                K_CLEAR:
                begin
                    count_next = '0;
                    sum_next   = '0;
                    res_status = STS_DONE;
                end
                K_IGNORE:
                begin
                    res_status = STS_IGNORED;
                end
            endcase
        end
    end

    // slot and count carry only their low bits when the table is wide
    assign slot_ext  = {{SLOT_W{1'b0}}, (res_slot_sel ? best_idx_reg : IDX_W'(0))};
    assign count_ext = {{COUNT_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_next            = rsp_reg;
        rsp_valid_next      = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_next.status     = res_status;
            rsp_next.slot       = slot_ext[SLOT_W-1:0];
            rsp_next.live_count = count_ext[COUNT_W-1:0];
            rsp_next.live_total = sum_next;
            rsp_valid_next      = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue)
        begin
            mem_q <= mem[issue_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= K_IGNORE;
            issue_idx_reg  <= '0;
            rd_pending_reg <= 1'b0;
            found_reg      <= 1'b0;
            add_seq_reg    <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                kind_reg <= in_kind;
            end
            issue_idx_reg  <= issue_idx_next;
            rd_pending_reg <= cmd.rd_issue;
            found_reg      <= found_next;
            add_seq_reg    <= add_seq_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= req_data.address;
            len_reg  <= req_data.length;
        end
        rd_idx_reg   <= issue_idx_reg[IDX_W-1:0];
        best_idx_reg <= best_idx_next;
        best_age_reg <= best_age_next;
        best_len_reg <= best_len_next;
        rsp_reg      <= rsp_next;
    end

    always_comb
    begin
        sts.in_kind    = in_kind;
        sts.kind       = kind_reg;
        sts.issue_done = (issue_idx_reg == CNT_W'(TABLE_ENTRIES));
        sts.rd_pending = rd_pending_reg;
        sts.found      = found_reg;
        sts.out_free   = out_free;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    `ALT_ASSERT(a_count_bound, count_reg <= CNT_W'(TABLE_ENTRIES), "live count above table size")
    `ALT_ASSERT(a_commit_shows_word, cmd.commit |=> rsp_valid_reg, "commit did not load output word")

endmodule

`default_nettype wire

>>> rtl/allocation_leak_tracker_core.sv
// top level of the allocation leak tracker: config register, controller and datapath
`default_nettype none

// Tracks up to TABLE_ENTRIES live allocations (address, length) in an on-chip table
// memory and answers every request word with one response word carrying the status,
// the slot touched and the live count and live byte total. The table is walked one
// entry per cycle through the memory's single read port. An add or delete scans the
// table (an add that finds a free slot stops early, at the first free slot), a clear
// writes every entry, and an ignored request goes straight to commit; the commit step
// waits while the previous response is still held. After reset a clearing pass
// writes every table entry, one per cycle, with req_ready held low until it ends;
// the tracking enable register can be written meanwhile.
// A finished response waits in an output register, so the next request is accepted
// before the previous response is taken.

module allocation_leak_tracker_core
    import alt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire req_t                  req_data,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output rsp_t                       rsp_data
);

    logic     track_en_reg;
    logic     track_en_next;
    logic     cfg_wr;
    ctl_cmd_t cmd;
    dp_sts_t  sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        track_en_next = track_en_reg;
        if (cfg_wr && (paddr[2] == REG_TRACK_ENABLE))
        begin
            track_en_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_en_reg <= 1'b0;
        end
        else
        begin
            track_en_reg <= track_en_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TRACK_ENABLE)
        begin
            prdata = {{(APB_DATA_W-1){1'b0}}, track_en_reg};
        end
    end

    alt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    alt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .track_en  (track_en_reg),
        .req_data  (req_data),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

>>> dv/alloc_table_checker.sv
// checker for the allocation leak tracker: tracks the table from observed words and checks replies
`default_nettype none

module alloc_table_checker
    import alt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic                  pready,
    input  wire logic                  req_valid,
    input  wire logic                  req_ready,
    input  wire req_t                  req_data,
    input  wire logic                  rsp_valid,
    input  wire logic                  rsp_ready,
    input  wire rsp_t                  rsp_data,
    output int                         mismatch_count,
    output int                         replies_outstanding
);

    logic [31:0] slot_addr  [TABLE_ENTRIES];
    logic [31:0] slot_len   [TABLE_ENTRIES];
    logic [31:0] slot_stamp [TABLE_ENTRIES];
    logic [31:0] add_seq;
    int          live_cnt;
    logic [31:0] live_sum;
    logic        track_en;

    rsp_t        replies_due[$];
    rsp_t        want;
    int          errs = 0;

    function automatic void wipe_table();
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            slot_addr[i]  = '0;
            slot_len[i]   = '0;
            slot_stamp[i] = '0;
        end
        live_cnt = 0;
        live_sum = '0;
    endfunction

    // updates the tracked table for one request word and returns the reply it owes
    function automatic rsp_t apply_alloc_word(req_t w);
        rsp_t        r;
        int          i;
        int          pick;
        logic [31:0] age;
        logic [31:0] best_age;
        r.status = STS_IGNORED;
        r.slot = '0;
        pick = -1;
        best_age = '0;
        if (w.opcode == OP_CLEAR)
        begin
            wipe_table();
            r.status = STS_DONE;
        end
        else if ((w.opcode == OP_ADD || w.opcode == OP_DELETE) && track_en && w.address != '0)
        begin
            if (w.opcode == OP_ADD)
            begin
                r.status = STS_FULL;
                for (i = 0; i < TABLE_ENTRIES && pick < 0; i++)
                begin
                    if (slot_addr[i] == '0)
                        pick = i;
                end
                if (pick >= 0)
                begin
                    slot_addr[pick]  = w.address;
                    slot_len[pick]   = w.length;
                    slot_stamp[pick] = add_seq;
                    add_seq = add_seq + 32'd1;
                    live_cnt++;
                    live_sum = live_sum + w.length;
                    r.slot = SLOT_W'(pick);
                    r.status = STS_DONE;
                end
            end
            else
            begin
                // youngest matching entry wins, lowest slot on a tie
                for (i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (slot_addr[i] == w.address)
                    begin
                        age = add_seq - slot_stamp[i];
                        if (pick < 0 || age < best_age)
                        begin
                            pick = i;
                            best_age = age;
                        end
                    end
                end
                if (pick >= 0)
                begin
                    live_sum = live_sum - slot_len[pick];
                    slot_addr[pick] = '0;
                    slot_len[pick]  = '0;
                    if (live_cnt > 0)
                        live_cnt--;
                    r.slot = SLOT_W'(pick);
                    r.status = STS_DONE;
                end
                else
                begin
                    r.status = STS_NOT_FOUND;
                end
            end
        end
        r.live_count = COUNT_W'(live_cnt);
        r.live_total = live_sum;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_table();
            add_seq = '0;
            track_en = 1'b0;
            replies_due.delete();
            replies_outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && (paddr >> 2) == APB_ADDR_W'(REG_TRACK_ENABLE))
                track_en = pwdata[0];

            if (rsp_valid && rsp_ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("reply word with none outstanding: %p", rsp_data);
                    errs++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (rsp_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                        errs++;
                    end
                    if (rsp_data.slot !== want.slot)
                    begin
                        $error("slot: expected %0d, got %0d", want.slot, rsp_data.slot);
                        errs++;
                    end
                    if (rsp_data.live_count !== want.live_count)
                    begin
                        $error("live_count: expected %0d, got %0d",
                               want.live_count, rsp_data.live_count);
                        errs++;
                    end
                    if (rsp_data.live_total !== want.live_total)
                    begin
                        $error("live_total: expected %h, got %h",
                               want.live_total, rsp_data.live_total);
                        errs++;
                    end
                end
            end

            if (req_valid && req_ready)
                replies_due.push_back(apply_alloc_word(req_data));

            replies_outstanding <= replies_due.size();
            mismatch_count <= errs;
        end
    end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// testbench top for the allocation leak tracker: clock, reset, stimulus and verdict
`default_nettype none

module tb_top;
    import alt_pkg::*;

    localparam int ENTRIES = 64;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ENABLE_ADDR = APB_ADDR_W'(REG_TRACK_ENABLE) << 2;
    localparam int POOL_SIZE = 24;
    localparam int EPISODE_WORDS = 65;

    typedef enum int {
        EP_FILL,
        EP_CHURN,
        EP_DRAIN
    } episode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req_data = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp_data;

    int                    mismatch_count;
    int                    replies_outstanding;
    int                    words_sent = 0;
    int                    words_taken = 0;
    logic [31:0]           addr_pool [POOL_SIZE];
    episode_t              plan [6] = '{EP_FILL, EP_CHURN, EP_FILL, EP_DRAIN, EP_CHURN, EP_FILL};

    always #1 clk = ~clk;

    allocation_leak_tracker_core #(
        .TABLE_ENTRIES(ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data(rsp_data)
    );

    alloc_table_checker #(
        .TABLE_ENTRIES(ENTRIES)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .pready(pready),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data(rsp_data),
        .mismatch_count(mismatch_count),
        .replies_outstanding(replies_outstanding)
    );

    task automatic write_enable(input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ENABLE_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_word(input logic [1:0] op, input logic [31:0] key,
                             input logic [31:0] len);
        int gap;
        // every fourth stretch of words goes back to back
        if ((words_sent / 30) % 4 == 2)
            gap = 0;
        else
            gap = $urandom_range(0, 16);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= '{opcode: op, address: key, length: len};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // lower valid and wait until every reply has been taken
    task automatic drain_replies();
        req_valid <= 1'b0;
        @(posedge clk);
        while (replies_outstanding != 0)
            @(posedge clk);
    endtask

    task automatic send_random(input episode_t ep);
        int          roll;
        logic [31:0] key;
        logic [31:0] len;
        roll = $urandom_range(0, 99);
        key = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        len = $urandom;
        if (ep == EP_FILL)
        begin
            if (roll < 93)
                send_word(OP_ADD, key, len);
            else if (roll < 97)
                send_word(OP_DELETE, key, len);
            else if (roll < 98)
                send_word(OP_ADD, '0, len);
            else if (roll < 99)
                send_word(OP_SPARE, $urandom, len);
            else
                send_word(OP_DELETE, $urandom, len);
        end
        else if (ep == EP_CHURN)
        begin
            if (roll < 48)
                send_word(OP_ADD, key, len);
            else if (roll < 90)
                send_word(OP_DELETE, key, len);
            else if (roll < 93)
                send_word(OP_DELETE, $urandom, len);
            else if (roll < 95)
                send_word(OP_CLEAR, $urandom, len);
            else if (roll < 97)
                send_word(OP_ADD, '0, len);
            else
                send_word(OP_SPARE, $urandom, len);
        end
        else
        begin
            if (roll < 15)
                send_word(OP_ADD, key, len);
            else if (roll < 92)
                send_word(OP_DELETE, key, len);
            else if (roll < 95)
                send_word(OP_DELETE, '0, len);
            else if (roll < 97)
                send_word(OP_CLEAR, key, len);
            else
                send_word(OP_SPARE, key, len);
        end
    endtask

    // reply side: random stalls, two long hold-offs so the block backs up
    initial
    begin
        int stall;
        forever
        begin
            if (words_taken == 120 || words_taken == 330)
                stall = 800;
            else if ((words_taken / 25) % 4 == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 16);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            words_taken++;
        end
    end

    initial
    begin
        int i;
        int ep;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tracking still off after reset
        send_word(OP_ADD, 32'h0000_0005, 32'h0000_0040);
        send_word(OP_DELETE, 32'h0000_0005, 32'h0);
        send_word(OP_CLEAR, 32'h0, 32'h0);
        send_word(OP_SPARE, 32'h1234_5678, 32'h9abc_def0);
        drain_replies();
        write_enable(32'h0000_0001);

        send_word(OP_ADD, 32'h0, 32'h0000_0007);
        send_word(OP_DELETE, 32'h0, 32'h0);
        send_word(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // total wraps past 2^32
        send_word(OP_ADD, 32'h0000_0001, 32'h0000_0001);
        send_word(OP_ADD, 32'h0000_1000, 32'h0000_0010);
        send_word(OP_ADD, 32'h0000_1000, 32'h0000_0020);
        // duplicate key: the newer entry goes first
        send_word(OP_DELETE, 32'h0000_1000, 32'h0);
        send_word(OP_ADD, 32'h0000_1000, 32'h0000_0030);
        send_word(OP_DELETE, 32'h0000_1000, 32'hFFFF_FFFF);
        send_word(OP_DELETE, 32'h0000_2222, 32'h0);
        send_word(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_DELETE, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        addr_pool[0] = 32'hFFFF_FFFF;
        addr_pool[1] = 32'h8000_0000;
        addr_pool[2] = 32'h0000_0001;
        for (i = 3; i < POOL_SIZE; i++)
        begin
            addr_pool[i] = $urandom;
            if (addr_pool[i] == '0)
                addr_pool[i] = 32'h0000_0100;
        end

        for (ep = 0; ep < 3; ep++)
            for (i = 0; i < EPISODE_WORDS; i++)
                send_random(plan[ep]);
        drain_replies();

        write_enable(32'h0000_0000);
        for (i = 0; i < 40; i++)
            send_random(EP_CHURN);
        drain_replies();

        write_enable(32'hFFFF_FFFF);
        for (ep = 3; ep < 6; ep++)
            for (i = 0; i < EPISODE_WORDS; i++)
                send_random(plan[ep]);
        drain_replies();

        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #1500000;
        $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
